/* rtl/core/utf8v_pkg.sv */
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants for the UTF-8 string validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned CodeW = 21;

  localparam logic [CodeW-1:0] MaxCodePoint  = 21'h10FFFF;
  localparam logic [CodeW-1:0] SurrogateLo   = 21'h00D800;
  localparam logic [CodeW-1:0] SurrogateHi   = 21'h00DFFF;
  localparam logic [CodeW-1:0] MinTwoByte    = 21'h000080;
  localparam logic [CodeW-1:0] MinThreeByte  = 21'h000800;
  localparam logic [CodeW-1:0] MinFourByte   = 21'h010000;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] LeadMask2  = 8'hE0;
  localparam logic [7:0] LeadTag2   = 8'hC0;
  localparam logic [7:0] LeadMask3  = 8'hF0;
  localparam logic [7:0] LeadTag3   = 8'hE0;
  localparam logic [7:0] LeadMask4  = 8'hF8;
  localparam logic [7:0] LeadTag4   = 8'hF0;
  localparam logic [7:0] TrailMask  = 8'hC0;
  localparam logic [7:0] TrailTag   = 8'h80;
  localparam logic [7:0] TrailBits  = 8'h3F;
  localparam logic [7:0] Lead2Bits  = 8'h1F;
  localparam logic [7:0] Lead3Bits  = 8'h0F;
  localparam logic [7:0] Lead4Bits  = 8'h07;

  // Sequence length codes (number of continuation bytes).
  localparam logic [1:0] SeqNone  = 2'd0;
  localparam logic [1:0] SeqTwo   = 2'd1;
  localparam logic [1:0] SeqThree = 2'd2;
  localparam logic [1:0] SeqFour  = 2'd3;

  typedef struct packed {
    logic [1:0]       trail_left;
    logic [1:0]       seq_length;
    logic [CodeW-1:0] code_accum;
    logic             error_seen;
  } dec_state_t;

  localparam dec_state_t StateClear = '{
    trail_left: 2'd0, seq_length: SeqNone, code_accum: '0, error_seen: 1'b0
  };

endpackage

/* rtl/core/utf8v_step.sv */
// ----------------------------------------------------------------------------
// utf8v_step
// Next-state logic of the decoder for one byte of a string.
// ----------------------------------------------------------------------------
module utf8v_step (
  input  utf8v_pkg::dec_state_t cur_i,
  input  logic [7:0]            byte_i,
  output utf8v_pkg::dec_state_t nxt_o
);

  logic [1:0]                  trail_dec;
  logic [utf8v_pkg::CodeW-1:0] code_shift;

  assign trail_dec  = cur_i.trail_left - 2'd1;
  assign code_shift = {cur_i.code_accum[utf8v_pkg::CodeW-7:0],
                       byte_i[5:0] & utf8v_pkg::TrailBits[5:0]};

  always_comb begin
    nxt_o = cur_i;
    if (!cur_i.error_seen) begin
      if (cur_i.trail_left == 2'd0) begin
        // Lead byte.
        if (byte_i < utf8v_pkg::AsciiLimit) begin
          if (byte_i == 8'h00) begin
            nxt_o.error_seen = 1'b1;
          end
        end else if ((byte_i & utf8v_pkg::LeadMask2) == utf8v_pkg::LeadTag2) begin
          nxt_o.code_accum = {16'd0, byte_i[4:0] & utf8v_pkg::Lead2Bits[4:0]};
          if (byte_i[4:1] == 4'd0) begin
            nxt_o.error_seen = 1'b1;
          end
          nxt_o.trail_left = 2'd1;
          nxt_o.seq_length = utf8v_pkg::SeqTwo;
        end else if ((byte_i & utf8v_pkg::LeadMask3) == utf8v_pkg::LeadTag3) begin
          nxt_o.code_accum = {17'd0, byte_i[3:0] & utf8v_pkg::Lead3Bits[3:0]};
          nxt_o.trail_left = 2'd2;
          nxt_o.seq_length = utf8v_pkg::SeqThree;
        end else if ((byte_i & utf8v_pkg::LeadMask4) == utf8v_pkg::LeadTag4) begin
          nxt_o.code_accum = {18'd0, byte_i[2:0] & utf8v_pkg::Lead4Bits[2:0]};
          nxt_o.trail_left = 2'd3;
          nxt_o.seq_length = utf8v_pkg::SeqFour;
        end else begin
          nxt_o.error_seen = 1'b1;
        end
      end else if ((byte_i & utf8v_pkg::TrailMask) != utf8v_pkg::TrailTag) begin
        nxt_o.error_seen = 1'b1;
      end else begin
        nxt_o.code_accum = code_shift;
        nxt_o.trail_left = trail_dec;
        if (trail_dec == 2'd0) begin
          // Sequence complete: range, surrogate and overlong checks.
          if (code_shift > utf8v_pkg::MaxCodePoint) begin
            nxt_o.error_seen = 1'b1;
          end
          if (code_shift inside {[utf8v_pkg::SurrogateLo:utf8v_pkg::SurrogateHi]}) begin
            nxt_o.error_seen = 1'b1;
          end
          case (cur_i.seq_length)
            utf8v_pkg::SeqTwo: begin
              if (code_shift < utf8v_pkg::MinTwoByte) nxt_o.error_seen = 1'b1;
            end
            utf8v_pkg::SeqThree: begin
              if (code_shift < utf8v_pkg::MinThreeByte) nxt_o.error_seen = 1'b1;
            end
            utf8v_pkg::SeqFour: begin
              if (code_shift < utf8v_pkg::MinFourByte) nxt_o.error_seen = 1'b1;
            end
            default: begin
            end
          endcase
          nxt_o.code_accum = '0;
          nxt_o.seq_length = utf8v_pkg::SeqNone;
        end
      end
    end
  end

endmodule

/* rtl/core/utf8_string_validator_unit.sv */
// ----------------------------------------------------------------------------
// utf8_string_validator_unit
// Checks a byte stream, one string at a time, for well-formed UTF-8 without NUL.
// ----------------------------------------------------------------------------
// A verdict is registered: its item waits in the input register, and the
// verdict enters the output register when the decoder takes that item.
// Throughput: one byte per cycle, set by the single input register feeding the
// decoder state update, unless an item that ends a string meets a full output
// register not being read; middle bytes flow on while a verdict waits. Reset
// (rst_ni low, asynchronous) empties both registers and clears the decoder state.
module utf8_string_validator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       last_byte_i,
  input  logic       empty_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o
);

  // Input register: one item waiting for the decoder.
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       empty_q;

  // Decoder state, carried between the bytes of a string.
  utf8v_pkg::dec_state_t state_q, state_d, step_nxt;

  // Output register holding one verdict.
  logic out_valid_q;
  logic res_q, res_d;

  logic ends_string;
  logic out_free;
  logic dec_fire;

  utf8v_step u_step (
    .cur_i  (state_q),
    .byte_i (byte_q),
    .nxt_o  (step_nxt)
  );

  // An item that ends a string needs room in the output register; a middle
  // byte only updates the state and can always proceed.
  assign ends_string = last_q | empty_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign dec_fire    = in_valid_q && (!ends_string || out_free);
  assign in_ready_o  = !in_valid_q || dec_fire;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    if (dec_fire) begin
      if (empty_q) begin
        // An empty-string marker also abandons any string in progress.
        state_d = utf8v_pkg::StateClear;
        res_d   = 1'b1;
      end else if (last_q) begin
        // Truncated sequences are rejected here as well.
        res_d   = !step_nxt.error_seen && (step_nxt.trail_left == 2'd0);
        state_d = utf8v_pkg::StateClear;
      end else begin
        state_d = step_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= utf8v_pkg::StateClear;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (dec_fire && ends_string) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      state_q <= state_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= byte_value_i;
      last_q  <= last_byte_i;
      empty_q <= empty_string_i;
    end
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;

endmodule

/* rtl/core/utf8v_checker.sv */
// ----------------------------------------------------------------------------
// utf8v_checker
// Port-level assertions for the UTF-8 string validator, bound to the top level.
// ----------------------------------------------------------------------------
module utf8v_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] byte_value_i,
  input logic       last_byte_i,
  input logic       empty_string_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       valid_res_o
);

  // A pending verdict stays until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(valid_res_o))
    else $error("verdict dropped or changed while stalled");

  // Input back-pressure only comes from a full, stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // An empty-string marker reaching a free output yields a positive verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && empty_string_i) ##1 !out_valid_o
      |=> out_valid_o && valid_res_o)
    else $error("empty string not reported as valid");

  // A string ending in NUL is always rejected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !empty_string_i && last_byte_i &&
     byte_value_i == 8'h00) ##1 !out_valid_o
      |=> out_valid_o && !valid_res_o)
    else $error("string ending in NUL accepted");

endmodule

bind utf8_string_validator_unit utf8v_checker u_utf8v_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .byte_value_i   (byte_value_i),
  .last_byte_i    (last_byte_i),
  .empty_string_i (empty_string_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .valid_res_o    (valid_res_o)
);

/* bench/utf8_string_validator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_string_validator_unit_tb
// Self-checking bench for the UTF-8 string validator. Strings are streamed in
// one byte per item, each accepted item updates a behavioral decoder kept in
// the bench, and every verdict the block returns is compared in order with
// the decoder's prediction. Directed strings cover the markers and each
// rejection rule but the overlong four-byte form. Random strings follow under
// three idling patterns and one long receiver stall.
// ----------------------------------------------------------------------------
module utf8_string_validator_unit_tb;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni;

  always #6 clk_i = ~clk_i;

  // Block ports.
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] byte_value_i;
  logic       last_byte_i;
  logic       empty_string_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       valid_res_o;

  utf8_string_validator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .last_byte_i    (last_byte_i),
    .empty_string_i (empty_string_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .valid_res_o    (valid_res_o)
  );

  // Bench state. The decoder state mirrors what the block must hold between
  // bytes; verdicts are queued in the order their strings end.
  utf8v_pkg::dec_state_t decoder_st;
  logic        verdict_q[$];
  logic [7:0]  str_bytes[$];
  int unsigned items_sent;
  int unsigned error_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        expected_res;

  // Receiver hold-off. A test asks for a stall by bumping the request count;
  // the receiver process then counts the stall down on its own.
  int unsigned hold_len;
  int unsigned hold_req_cnt;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // --------------------------------------------------------------------------
  // Behavioral decoder
  // --------------------------------------------------------------------------

  // Opens a new sequence from a lead byte. ASCII stands alone, NUL is
  // rejected, and anything that is not a valid lead (a stray continuation,
  // 0xF8 and up) poisons the string.
  task automatic decode_lead(input logic [7:0] b);
    if (b < utf8v_pkg::AsciiLimit) begin
      if (b == 8'h00) decoder_st.error_seen = 1'b1;
    end else if ((b & utf8v_pkg::LeadMask2) == utf8v_pkg::LeadTag2) begin
      decoder_st.code_accum = utf8v_pkg::CodeW'(b & utf8v_pkg::Lead2Bits);
      // Leads 0xC0 and 0xC1 can only ever encode an overlong form.
      if (decoder_st.code_accum < 21'd2) decoder_st.error_seen = 1'b1;
      decoder_st.trail_left = 2'd1;
      decoder_st.seq_length = utf8v_pkg::SeqTwo;
    end else if ((b & utf8v_pkg::LeadMask3) == utf8v_pkg::LeadTag3) begin
      decoder_st.code_accum = utf8v_pkg::CodeW'(b & utf8v_pkg::Lead3Bits);
      decoder_st.trail_left = 2'd2;
      decoder_st.seq_length = utf8v_pkg::SeqThree;
    end else if ((b & utf8v_pkg::LeadMask4) == utf8v_pkg::LeadTag4) begin
      decoder_st.code_accum = utf8v_pkg::CodeW'(b & utf8v_pkg::Lead4Bits);
      decoder_st.trail_left = 2'd3;
      decoder_st.seq_length = utf8v_pkg::SeqFour;
    end else begin
      decoder_st.error_seen = 1'b1;
    end
  endtask

  // Folds one continuation byte into the code point. When the sequence is
  // complete the code point is checked for range, surrogates and overlong
  // encoding.
  task automatic decode_trail(input logic [7:0] b);
    logic [utf8v_pkg::CodeW-1:0] cp;
    if ((b & utf8v_pkg::TrailMask) != utf8v_pkg::TrailTag) begin
      decoder_st.error_seen = 1'b1;
    end else begin
      cp = {decoder_st.code_accum[utf8v_pkg::CodeW-7:0], b[5:0]};
      decoder_st.code_accum = cp;
      decoder_st.trail_left = decoder_st.trail_left - 2'd1;
      if (decoder_st.trail_left == 2'd0) begin
        if (cp > utf8v_pkg::MaxCodePoint) decoder_st.error_seen = 1'b1;
        if (cp inside {[utf8v_pkg::SurrogateLo:utf8v_pkg::SurrogateHi]})
          decoder_st.error_seen = 1'b1;
        if (decoder_st.seq_length == utf8v_pkg::SeqTwo && cp < utf8v_pkg::MinTwoByte)
          decoder_st.error_seen = 1'b1;
        if (decoder_st.seq_length == utf8v_pkg::SeqThree && cp < utf8v_pkg::MinThreeByte)
          decoder_st.error_seen = 1'b1;
        if (decoder_st.seq_length == utf8v_pkg::SeqFour && cp < utf8v_pkg::MinFourByte)
          decoder_st.error_seen = 1'b1;
        decoder_st.code_accum = '0;
        decoder_st.seq_length = utf8v_pkg::SeqNone;
      end
    end
  endtask

  // Applies one accepted item and queues the verdict it produces, if any.
  // An empty-string marker always passes and drops any string in progress.
  // Once a string is rejected its remaining bytes are skipped.
  task automatic predict_verdict(input logic [7:0] b, input logic last,
                                 input logic empty);
    if (empty) begin
      decoder_st = utf8v_pkg::StateClear;
      verdict_q = {verdict_q, 1'b1};
    end else begin
      if (!decoder_st.error_seen) begin
        if (decoder_st.trail_left == 2'd0) decode_lead(b);
        else decode_trail(b);
      end
      if (last) begin
        // A string that ends while continuation bytes are owed is truncated.
        verdict_q = {verdict_q,
                     !decoder_st.error_seen && decoder_st.trail_left == 2'd0};
        decoder_st = utf8v_pkg::StateClear;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sending side
  // --------------------------------------------------------------------------

  // Offers one item, optionally after a random idle gap, and holds it until
  // the block takes it. Valid stays high on return so that back-to-back items
  // need no extra edge on in_valid_i.
  task automatic send_item(input logic [7:0] value, input logic last,
                           input logic empty);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    byte_value_i   <= value;
    last_byte_i    <= last;
    empty_string_i <= empty;
    do @(posedge clk_i); while (!in_ready_o);
    predict_verdict(value, last, empty);
    items_sent++;
  endtask

  // Sends the buffered string with the last mark on its final byte.
  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++)
      send_item(str_bytes[i], i == str_bytes.size() - 1, 1'b0);
  endtask

  // The byte and last fields of a marker carry random junk on purpose.
  task automatic send_marker();
    send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // String construction
  // --------------------------------------------------------------------------

  // Appends a code point encoded in the given number of bytes. A length
  // larger than the code point needs yields an overlong form.
  task automatic append_code(input logic [utf8v_pkg::CodeW-1:0] cp, input int nbytes);
    case (nbytes)
      1: str_bytes = {str_bytes, cp[7:0]};
      2: begin
        str_bytes = {str_bytes, utf8v_pkg::LeadTag2 | {3'b0, cp[10:6]}};
        str_bytes = {str_bytes, utf8v_pkg::TrailTag | {2'b0, cp[5:0]}};
      end
      3: begin
        str_bytes = {str_bytes, utf8v_pkg::LeadTag3 | {4'b0, cp[15:12]}};
        str_bytes = {str_bytes, utf8v_pkg::TrailTag | {2'b0, cp[11:6]}};
        str_bytes = {str_bytes, utf8v_pkg::TrailTag | {2'b0, cp[5:0]}};
      end
      default: begin
        str_bytes = {str_bytes, utf8v_pkg::LeadTag4 | {5'b0, cp[20:18]}};
        str_bytes = {str_bytes, utf8v_pkg::TrailTag | {2'b0, cp[17:12]}};
        str_bytes = {str_bytes, utf8v_pkg::TrailTag | {2'b0, cp[11:6]}};
        str_bytes = {str_bytes, utf8v_pkg::TrailTag | {2'b0, cp[5:0]}};
      end
    endcase
  endtask

  // Picks a legal code point whose shortest form takes nbytes bytes, with a
  // bias toward the edges of each range.
  function automatic logic [utf8v_pkg::CodeW-1:0] pick_code(input int nbytes);
    logic [utf8v_pkg::CodeW-1:0] lo;
    logic [utf8v_pkg::CodeW-1:0] hi;
    logic [utf8v_pkg::CodeW-1:0] cp;
    case (nbytes)
      1: begin
        lo = 21'd1;
        hi = utf8v_pkg::MinTwoByte - 21'd1;
      end
      2: begin
        lo = utf8v_pkg::MinTwoByte;
        hi = utf8v_pkg::MinThreeByte - 21'd1;
      end
      3: begin
        lo = utf8v_pkg::MinThreeByte;
        hi = utf8v_pkg::MinFourByte - 21'd1;
      end
      default: begin
        lo = utf8v_pkg::MinFourByte;
        hi = utf8v_pkg::MaxCodePoint;
      end
    endcase
    if ($urandom_range(0, 7) == 0) cp = $urandom_range(0, 1) ? lo : hi;
    else cp = utf8v_pkg::CodeW'($urandom_range(lo, hi));
    // Move a surrogate out of the reserved block.
    if (cp inside {[utf8v_pkg::SurrogateLo:utf8v_pkg::SurrogateHi]})
      cp = cp ^ 21'h001000;
    return cp;
  endfunction

  function automatic int pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 1;
    else if (r < 6) return 2;
    else if (r < 8) return 3;
    return 4;
  endfunction

  task automatic append_good(input int count);
    int n;
    repeat (count) begin
      n = pick_len();
      append_code(pick_code(n), n);
    end
  endtask

  // Appends one defective piece of text, chosen among the rejection rules.
  task automatic append_flaw();
    int n;
    int k;
    case ($urandom_range(0, 6))
      0: str_bytes = {str_bytes, 8'h00};
      1: begin
        // Truncated sequence: a lead followed by too few continuation bytes.
        n = $urandom_range(2, 4);
        append_code(pick_code(n), n);
        repeat ($urandom_range(1, n - 1)) void'(str_bytes.pop_back());
      end
      2: begin
        k = $urandom_range(1, 3);
        append_code(pick_code(k), $urandom_range(k + 1, 4));
      end
      3: append_code(utf8v_pkg::CodeW'($urandom_range(utf8v_pkg::SurrogateLo,
                                                      utf8v_pkg::SurrogateHi)), 3);
      4: append_code(utf8v_pkg::CodeW'($urandom_range(utf8v_pkg::MaxCodePoint + 1,
                                                      21'h1FFFFF)), 4);
      5: str_bytes = {str_bytes, utf8v_pkg::TrailTag | 8'($urandom_range(0, 63))};
      default: str_bytes = {str_bytes, 8'($urandom_range(8'hF8, 8'hFF))};
    endcase
  endtask

  // Builds one random string: mostly well-formed text, some with one inserted
  // flaw and at times an overwritten byte, some raw noise.
  task automatic make_random_string();
    int unsigned kind;
    str_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      append_good($urandom_range(1, 5));
    end else if (kind < 88) begin
      append_good($urandom_range(0, 3));
      append_flaw();
      append_good($urandom_range(0, 2));
      // Overwriting a random byte sometimes lands in a flawed string as well.
      if ($urandom_range(0, 3) == 0)
        str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom);
    end else begin
      repeat ($urandom_range(1, 6)) str_bytes = {str_bytes, 8'($urandom)};
    end
    if (str_bytes.size() == 0) str_bytes = {str_bytes, 8'($urandom_range(1, 127))};
  endtask

  // --------------------------------------------------------------------------
  // Receiving side and checking
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Every verdict taken from the block must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $error("valid_res: no verdict expected, actual %0b", valid_res_o);
        error_count++;
      end else begin
        expected_res = verdict_q.pop_front();
        if (valid_res_o !== expected_res) begin
          $error("valid_res mismatch: expected %0b, actual %0b",
                 expected_res, valid_res_o);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Markers pass whatever their byte and last fields hold.
  task automatic test_empty_markers();
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
  endtask

  // One-byte strings: NUL, the top of ASCII, a stray continuation byte and
  // the first invalid lead.
  task automatic test_single_bytes();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hF8, 1'b1, 1'b0);
  endtask

  // Multi-byte forms: the smallest two-byte character, an overlong two-byte
  // lead, a surrogate, a code point past the top of the range and an
  // overlong three-byte form.
  task automatic test_multibyte_forms();
    str_bytes = '{8'hC2, 8'h80};              send_string();
    str_bytes = '{8'hC1, 8'hBF};              send_string();
    str_bytes = '{8'hED, 8'hA0, 8'h80};       send_string();
    str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_string();
    str_bytes = '{8'hE0, 8'h9F, 8'hBF};       send_string();
  endtask

  // A string that ends inside a sequence, and a bad continuation byte after
  // which the remaining bytes must be ignored.
  task automatic test_truncation_and_bad_trail();
    send_item(8'hE2, 1'b1, 1'b0);
    str_bytes = '{8'hC2, 8'h41, 8'hC2};
    send_string();
  endtask

  // A marker in the middle of a string drops the partial string, and only
  // the marker's verdict comes out.
  task automatic test_abandoned_string();
    send_item(8'hE2, 1'b0, 1'b0);
    send_marker();
  endtask

  // Random strings under one idling pattern until the item budget is used.
  // A few strings are cut short by a marker.
  task automatic test_random_strings(input int unsigned sender_idle,
                                     input int unsigned receiver_idle,
                                     input int unsigned budget);
    int unsigned stop_at;
    int unsigned r;
    int unsigned cut;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_marker();
      end else if (r < 9) begin
        make_random_string();
        cut = $urandom_range(1, str_bytes.size());
        for (int i = 0; i < cut; i++) send_item(str_bytes[i], 1'b0, 1'b0);
        send_marker();
      end else begin
        make_random_string();
        send_string();
      end
    end
  endtask

  // The receiver stops for a long stretch while strings keep coming, so the
  // block fills up and must stall its input.
  task automatic test_receiver_backpressure();
    hold_len = 120;
    hold_req_cnt++;
    test_random_strings(0, 0, 60);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int unsigned drain_cycles;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    byte_value_i   = 8'h00;
    last_byte_i    = 1'b0;
    empty_string_i = 1'b0;
    decoder_st     = utf8v_pkg::StateClear;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_len       = 0;
    hold_req_cnt   = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_markers();
    test_single_bytes();
    test_multibyte_forms();
    test_truncation_and_bad_trail();
    test_abandoned_string();
    test_random_strings(28, 64, 160);
    test_random_strings(64, 28, 160);
    test_random_strings(0, 0, 120);
    test_receiver_backpressure();

    // All items are in: stop offering and let the last verdicts drain.
    in_valid_i <= 1'b0;
    drain_cycles = 0;
    while (verdict_q.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end

    if (verdict_q.size() != 0) begin
      $error("valid_res: %0d verdicts never arrived", verdict_q.size());
      $display("TEST FAILED");
    end else begin
      // Then watch for any verdict the block should not give.
      repeat (10) @(posedge clk_i);
      if (error_count == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #4_800_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/utf8v_pkg.sv
rtl/core/utf8v_step.sv
rtl/core/utf8_string_validator_unit.sv
rtl/core/utf8v_checker.sv
bench/utf8_string_validator_unit_tb.sv
